// ===== hw/rtl/mdu_pkg.sv =====
package mdu_pkg;

	// Digit limits of a numeric reference
	localparam int MAX_DECIMAL_DIGITS = 7;
	localparam int MAX_HEX_DIGITS = 6;

	// Pending bytes: "&#" plus decimal digits, or "&#x" plus hex digits
	localparam int PEND_DEC = 2 + MAX_DECIMAL_DIGITS;
	localparam int PEND_HEX = 3 + MAX_HEX_DIGITS;
	localparam int PEND_DEPTH = (PEND_DEC > PEND_HEX) ? PEND_DEC : PEND_HEX;
	localparam int PEND_IW = $clog2(PEND_DEPTH);
	localparam int CNT_W = $clog2(PEND_DEPTH + 1);

	localparam int DIG_MAX = (MAX_DECIMAL_DIGITS > MAX_HEX_DIGITS) ?
		MAX_DECIMAL_DIGITS : MAX_HEX_DIGITS;
	localparam int DIG_W = $clog2(DIG_MAX + 1);

	// Tail bytes: a literal, a backslash pair or up to four UTF-8 bytes
	localparam int TAIL_MAX = 4;
	localparam int TAIL_IW = $clog2(TAIL_MAX);
	localparam int TAIL_W = $clog2(TAIL_MAX + 1);

	// Most output bytes that one input byte releases
	localparam int OUT_MAX = PEND_DEPTH + 1;
	localparam int IDX_W = $clog2(PEND_DEPTH + TAIL_MAX + 1);

	localparam int CODE_W = 24;

	// Command queue between parser and expander
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW = $clog2(CQ_DEPTH);
	localparam int CQ_CW = $clog2(CQ_DEPTH + 1);

	// Characters the parser reacts to
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_LX = 8'h78;
	localparam logic [7:0] CH_UX = 8'h58;

	// One input byte's worth of output: flushed pending bytes, then tail bytes
	typedef struct packed {
		logic [PEND_DEPTH-1:0][7:0] pend;
		logic [CNT_W-1:0]           pend_n;
		logic [TAIL_MAX-1:0][7:0]   tail;
		logic [TAIL_W-1:0]          tail_n;
		logic                       last;
	} mdu_cmd_t;

endpackage

// ===== hw/rtl/mdu_front.sv =====
module mdu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_acc,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	output mdu_pkg::mdu_cmd_t cmd,
	output logic             cmd_valid
);
	import mdu_pkg::*;

	typedef enum logic [2:0] {
		M_IDLE,
		M_BSL,
		M_AMP,
		M_HASH,
		M_DIG
	} mode_t;

	localparam logic [20:0] CP_MAX = 21'h10FFFF;
	localparam logic [20:0] CP_REPL = 21'h00FFFD;
	localparam logic [CODE_W-1:0] SUR_LO = CODE_W'(24'h00D800);
	localparam logic [CODE_W-1:0] SUR_HI = CODE_W'(24'h00DFFF);
	localparam logic [7:0] LEAD2 = 8'hC0;
	localparam logic [7:0] LEAD3 = 8'hE0;
	localparam logic [7:0] LEAD4 = 8'hF0;
	localparam logic [7:0] CONT = 8'h80;

	mode_t                      mode_q, mode_d;
	logic [PEND_DEPTH-1:0][7:0] pend_q;
	logic [CNT_W-1:0]           cnt_q, cnt_d;
	logic [DIG_W-1:0]           dig_q, dig_d;
	logic [CODE_W-1:0]          code_q, code_d;
	logic                       hex_q, hex_d;

	logic                       wr_en;
	logic [PEND_IW-1:0]         wr_idx;
	logic [CNT_W-1:0]           flush_n;
	logic [TAIL_MAX-1:0][7:0]   tail;
	logic [TAIL_W-1:0]          tail_n;

	logic [TAIL_MAX-1:0][7:0]   utf_b;
	logic [TAIL_W-1:0]          utf_n;

	function automatic logic is_punct(input logic [7:0] c);
		return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
			(c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
	endfunction

	function automatic logic is_dec(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
	endfunction

	// Letters a-f and A-F carry their value minus nine in the low nibble
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		return is_dec(c) ? c[3:0] : c[3:0] + 4'd9;
	endfunction

	// Encode the collected code point as UTF-8
	always_comb begin
		logic        bad;
		logic [20:0] cp;
		bad = (code_q == '0) || (code_q > CODE_W'(CP_MAX)) ||
			(code_q >= SUR_LO && code_q <= SUR_HI);
		cp = bad ? CP_REPL : code_q[20:0];
		utf_b = '0;
		if (cp <= 21'h00007F) begin
			utf_b[0] = cp[7:0];
			utf_n = TAIL_W'(1);
		end else if (cp <= 21'h0007FF) begin
			utf_b[0] = LEAD2 | {3'b000, cp[10:6]};
			utf_b[1] = CONT | {2'b00, cp[5:0]};
			utf_n = TAIL_W'(2);
		end else if (cp <= 21'h00FFFF) begin
			utf_b[0] = LEAD3 | {4'b0000, cp[15:12]};
			utf_b[1] = CONT | {2'b00, cp[11:6]};
			utf_b[2] = CONT | {2'b00, cp[5:0]};
			utf_n = TAIL_W'(3);
		end else begin
			utf_b[0] = LEAD4 | {5'b00000, cp[20:18]};
			utf_b[1] = CONT | {2'b00, cp[17:12]};
			utf_b[2] = CONT | {2'b00, cp[11:6]};
			utf_b[3] = CONT | {2'b00, cp[5:0]};
			utf_n = TAIL_W'(4);
		end
	end

	// Classify the byte against the current parse mode
	always_comb begin
		logic             restart;
		logic             brk;
		logic             push;
		logic             dig_ok;
		logic [3:0]       d;
		logic [DIG_W-1:0] limit;
		mode_d = mode_q;
		cnt_d = cnt_q;
		dig_d = dig_q;
		code_d = code_q;
		hex_d = hex_q;
		wr_en = 1'b0;
		wr_idx = cnt_q[PEND_IW-1:0];
		flush_n = '0;
		tail = '0;
		tail_n = '0;
		restart = 1'b0;
		brk = 1'b0;
		push = 1'b0;
		dig_ok = hex_q ? is_hex(in_byte) : is_dec(in_byte);
		d = hex_q ? hex_val(in_byte) : in_byte[3:0];
		limit = hex_q ? DIG_W'(MAX_HEX_DIGITS) : DIG_W'(MAX_DECIMAL_DIGITS);

		unique case (mode_q)
			M_IDLE: begin
				restart = 1'b1;
			end
			M_BSL: begin
				if (is_punct(in_byte)) begin
					tail[0] = in_byte;
					tail_n = TAIL_W'(1);
				end else begin
					tail[0] = CH_BSL;
					tail[1] = in_byte;
					tail_n = TAIL_W'(2);
				end
				mode_d = M_IDLE;
			end
			M_AMP: begin
				if (in_byte == CH_HASH) begin
					push = 1'b1;
					mode_d = M_HASH;
				end else begin
					brk = 1'b1;
				end
			end
			M_HASH: begin
				if (in_byte == CH_LX || in_byte == CH_UX) begin
					push = 1'b1;
					hex_d = 1'b1;
					dig_d = '0;
					code_d = '0;
					mode_d = M_DIG;
				end else if (is_dec(in_byte) && MAX_DECIMAL_DIGITS > 0) begin
					push = 1'b1;
					hex_d = 1'b0;
					dig_d = DIG_W'(1);
					code_d = {{(CODE_W-4){1'b0}}, in_byte[3:0]};
					mode_d = M_DIG;
				end else begin
					brk = 1'b1;
				end
			end
			M_DIG: begin
				if (in_byte == CH_SEMI && dig_q != '0) begin
					tail = utf_b;
					tail_n = utf_n;
					mode_d = M_IDLE;
					cnt_d = '0;
					dig_d = '0;
					code_d = '0;
					hex_d = 1'b0;
				end else if (dig_ok && dig_q < limit) begin
					push = 1'b1;
					dig_d = dig_q + DIG_W'(1);
					if (hex_q) begin
						code_d = {code_q[CODE_W-5:0], d};
					end else begin
						code_d = {code_q[CODE_W-4:0], 3'b000} + {code_q[CODE_W-2:0], 1'b0} +
							{{(CODE_W-4){1'b0}}, d};
					end
				end else begin
					brk = 1'b1;
				end
			end
			default: begin
				mode_d = M_IDLE;
			end
		endcase

		// Flush what was collected and take the byte again from idle
		if (brk) begin
			flush_n = cnt_q;
			restart = 1'b1;
		end

		if (restart) begin
			mode_d = M_IDLE;
			cnt_d = '0;
			dig_d = '0;
			code_d = '0;
			hex_d = 1'b0;
			if (in_byte == CH_BSL) begin
				mode_d = M_BSL;
			end else if (in_byte == CH_AMP) begin
				wr_en = 1'b1;
				wr_idx = '0;
				cnt_d = CNT_W'(1);
				mode_d = M_AMP;
			end else begin
				tail[0] = in_byte;
				tail_n = TAIL_W'(1);
			end
		end

		if (push) begin
			wr_en = 1'b1;
			cnt_d = cnt_q + CNT_W'(1);
		end

		// Final byte: drain whatever is still open
		if (in_last) begin
			if (mode_d == M_BSL) begin
				tail[0] = CH_BSL;
				tail_n = TAIL_W'(1);
			end else if (restart && mode_d == M_AMP) begin
				tail[0] = CH_AMP;
				tail_n = TAIL_W'(1);
			end else if (push) begin
				flush_n = cnt_d;
			end
			mode_d = M_IDLE;
			cnt_d = '0;
			dig_d = '0;
			code_d = '0;
			hex_d = 1'b0;
		end
	end

	// Build the command; the current byte sits after the pending ones
	always_comb begin
		cmd.pend = pend_q;
		if (cnt_q < CNT_W'(PEND_DEPTH)) begin
			cmd.pend[cnt_q[PEND_IW-1:0]] = in_byte;
		end
		cmd.pend_n = flush_n;
		cmd.tail = tail;
		cmd.tail_n = tail_n;
		cmd.last = in_last;
	end

	assign cmd_valid = (flush_n != '0) || (tail_n != '0);

	// Hold parse state, advance on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			cnt_q <= '0;
			dig_q <= '0;
			code_q <= '0;
			hex_q <= 1'b0;
		end else if (in_acc) begin
			mode_q <= mode_d;
			cnt_q <= cnt_d;
			dig_q <= dig_d;
			code_q <= code_d;
			hex_q <= hex_d;
		end
	end

	// Pending bytes need no reset; only entries below the count are read
	always_ff @(posedge clk) begin
		if (in_acc && wr_en) begin
			pend_q[wr_idx] <= in_byte;
		end
	end

endmodule

// ===== hw/rtl/mdu_cmd_fifo.sv =====
module mdu_cmd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  mdu_pkg::mdu_cmd_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output mdu_pkg::mdu_cmd_t rd_data,
	output logic             empty
);
	import mdu_pkg::*;

	mdu_cmd_t           mem_q [CQ_DEPTH];
	logic [CQ_AW-1:0]   wr_ptr_q;
	logic [CQ_AW-1:0]   rd_ptr_q;
	logic [CQ_CW-1:0]   count_q;

	assign full = count_q == CQ_CW'(CQ_DEPTH);
	assign empty = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + CQ_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + CQ_AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CQ_CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CQ_CW'(1);
			end
		end
	end

	// Store commands
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hw/rtl/mdu_back.sv =====
module mdu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mdu_pkg::mdu_cmd_t cq_data,
	input  logic             cq_empty,
	output logic             cq_pop,
	output logic [7:0]       out_byte,
	output logic             run_end,
	output logic             stream_end,
	output logic             empty,
	input  logic             pop
);
	import mdu_pkg::*;

	mdu_cmd_t           cur_q;
	logic               cur_v_q;
	logic [IDX_W-1:0]   idx_q;
	logic [7:0]         byte_q;
	logic               run_q;
	logic               stream_q;
	logic               out_v_q;

	logic [IDX_W-1:0]   last_idx;
	logic [IDX_W-1:0]   tidx;
	logic [7:0]         cur_byte;
	logic               adv;
	logic               at_end;
	logic               load;

	assign last_idx = IDX_W'(cur_q.pend_n) + IDX_W'(cur_q.tail_n) - IDX_W'(1);
	assign tidx = idx_q - IDX_W'(cur_q.pend_n);
	assign cur_byte = (idx_q < IDX_W'(cur_q.pend_n)) ? cur_q.pend[idx_q[PEND_IW-1:0]] :
		cur_q.tail[tidx[TAIL_IW-1:0]];

	// Move one byte into the output register when it is free or being taken
	assign adv = cur_v_q && (!out_v_q || pop);
	assign at_end = idx_q == last_idx;
	assign load = !cq_empty && (!cur_v_q || (adv && at_end));
	assign cq_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			out_v_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
			if (load) begin
				cur_v_q <= 1'b1;
				idx_q <= '0;
			end else if (adv) begin
				if (at_end) begin
					cur_v_q <= 1'b0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= cq_data;
		end
		if (adv) begin
			byte_q <= cur_byte;
			run_q <= at_end;
			stream_q <= at_end && cur_q.last;
		end
	end

	assign out_byte = byte_q;
	assign run_end = run_q;
	assign stream_end = stream_q;
	assign empty = !out_v_q;

endmodule

// ===== hw/rtl/markdown_unescape_numeric_ref.sv =====
// Streaming text unescaper: backslash escapes of ASCII punctuation are resolved and HTML
// numeric character references (&#digits; and &#x hex;) become UTF-8, with U+FFFD for zero,
// surrogates and values past U+10FFFF; broken references pass through literally. The parser
// takes one byte per cycle and writes at most one command per byte into a four-entry command
// queue; the expander drains commands at one output byte per cycle while out_byte is popped.
// An input byte releases 0 to 10 output bytes, and the input stalls (full) only when the
// command queue fills. A result passes through the command queue, the expander's command
// register and the output register. run_end marks the last byte released by one input byte,
// stream_end the last byte of a text closed by in_last.
module markdown_unescape_numeric_ref (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       push,
	output logic       full,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       stream_end,
	output logic       empty,
	input  logic       pop
);
	import mdu_pkg::*;

	mdu_cmd_t cmd;
	mdu_cmd_t cq_data;
	logic     cmd_valid;
	logic     in_acc;
	logic     cq_wr;
	logic     cq_empty;
	logic     cq_pop;

	assign in_acc = push && !full;
	assign cq_wr = in_acc && cmd_valid;

	mdu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_acc    (in_acc),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.cmd       (cmd),
		.cmd_valid (cmd_valid)
	);

	mdu_cmd_fifo u_cq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cq_wr),
		.wr_data (cmd),
		.full    (full),
		.rd_en   (cq_pop),
		.rd_data (cq_data),
		.empty   (cq_empty)
	);

	mdu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cq_data    (cq_data),
		.cq_empty   (cq_empty),
		.cq_pop     (cq_pop),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.stream_end (stream_end),
		.empty      (empty),
		.pop        (pop)
	);

	// The end of a text is always the end of a run
	a_stream_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && stream_end |-> run_end)
		else $error("stream_end without run_end");

	// A final byte always releases output
	a_last_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_last |-> cmd_valid)
		else $error("final byte released no output");

	// A command never carries more bytes than one input byte can release
	a_cmd_len: assert property (@(posedge clk) disable iff (!arst_n)
		cq_wr |-> (IDX_W'(cmd.pend_n) + IDX_W'(cmd.tail_n)) <= IDX_W'(OUT_MAX))
		else $error("command longer than allowed");

	// Nothing is read from an empty command queue
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |-> !cq_empty)
		else $error("command queue underrun");

endmodule
